[sv/rgbyc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rgbyc_pkg;

    // Field and datapath widths
    localparam int COMP_W = 8;
    localparam int NUM_W  = 20;                  // signed numerator in thousandths
    localparam int MAG_W  = NUM_W - 1;           // magnitude plus rounding bias
    localparam int REC_W  = 20;                  // width of the 1/1000 reciprocal
    localparam int SHIFT  = 29;                  // reciprocal scale, 2**SHIFT
    localparam int PROD_W = MAG_W + REC_W;
    localparam int Q_W    = PROD_W - SHIFT;      // quotient width
    localparam int SQ_W   = Q_W + 1;             // signed quotient width
    localparam int SUM_W  = SQ_W + 1;            // luma plus chroma term

    // ceil(2**29 / 1000); exact floor(n / 1000) for every n below 2**MAG_W
    localparam logic [REC_W-1:0] DIV_REC  = REC_W'(536871);
    localparam logic [MAG_W-1:0] RND_BIAS = MAG_W'(500);

    // Forward coefficients, thousandths (signs applied in the sums)
    localparam logic signed [NUM_W-1:0] K_Y_R  = NUM_W'(257);
    localparam logic signed [NUM_W-1:0] K_Y_G  = NUM_W'(504);
    localparam logic signed [NUM_W-1:0] K_Y_B  = NUM_W'(98);
    localparam logic signed [NUM_W-1:0] K_CB_R = NUM_W'(148);
    localparam logic signed [NUM_W-1:0] K_CB_G = NUM_W'(291);
    localparam logic signed [NUM_W-1:0] K_CB_B = NUM_W'(439);
    localparam logic signed [NUM_W-1:0] K_CR_R = NUM_W'(439);
    localparam logic signed [NUM_W-1:0] K_CR_G = NUM_W'(368);
    localparam logic signed [NUM_W-1:0] K_CR_B = NUM_W'(71);

    // Inverse coefficients, thousandths
    localparam logic signed [NUM_W-1:0] K_LUMA = NUM_W'(1164);
    localparam logic signed [NUM_W-1:0] K_R_CR = NUM_W'(1596);
    localparam logic signed [NUM_W-1:0] K_G_CB = NUM_W'(392);
    localparam logic signed [NUM_W-1:0] K_G_CR = NUM_W'(813);
    localparam logic signed [NUM_W-1:0] K_B_CB = NUM_W'(2017);

    // Offsets
    localparam logic signed [NUM_W-1:0] LUMA_OFS_N   = NUM_W'(16);
    localparam logic signed [NUM_W-1:0] CHROMA_OFS_N = NUM_W'(128);
    localparam logic signed [SQ_W-1:0]  LUMA_OFS     = SQ_W'(16);
    localparam logic signed [SQ_W-1:0]  CHROMA_OFS   = SQ_W'(128);
    localparam logic signed [SUM_W-1:0] PIX_MAX      = SUM_W'(255);
    localparam logic [COMP_W-1:0]       PIX_SAT      = '1;

    typedef enum logic {
        MODE_RGB2YCC = 1'b0,
        MODE_YCC2RGB = 1'b1
    } t_mode;

    // Side information that travels with each request
    typedef struct packed {
        t_mode mode;
        logic  last;
    } t_side;

    // Load enables of the two divider stages
    typedef struct packed {
        logic ld_mag;
        logic ld_mul;
    } t_div_ctl;

endpackage

`default_nettype wire

[sv/rgbyc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rgbyc_in_if;
    logic                        valid;
    logic                        ready;
    logic [rgbyc_pkg::COMP_W-1:0] comp_first;
    logic [rgbyc_pkg::COMP_W-1:0] comp_second;
    logic [rgbyc_pkg::COMP_W-1:0] comp_third;
    logic                        last_in;

    modport source (
        output valid, comp_first, comp_second, comp_third, last_in,
        input  ready
    );
    modport sink (
        input  valid, comp_first, comp_second, comp_third, last_in,
        output ready
    );
endinterface

`default_nettype wire

[sv/rgbyc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rgbyc_out_if;
    logic                        valid;
    logic                        ready;
    logic [rgbyc_pkg::COMP_W-1:0] res_first;
    logic [rgbyc_pkg::COMP_W-1:0] res_second;
    logic [rgbyc_pkg::COMP_W-1:0] res_third;
    logic                        last_out;

    modport source (
        output valid, res_first, res_second, res_third, last_out,
        input  ready
    );
    modport sink (
        input  valid, res_first, res_second, res_third, last_out,
        output ready
    );
endinterface

`default_nettype wire

[sv/rgbyc_matrix.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbyc_matrix (
    input  wire                                  i_clk,
    input  wire                                  i_ld,
    input  wire        [rgbyc_pkg::COMP_W-1:0]   i_a,
    input  wire        [rgbyc_pkg::COMP_W-1:0]   i_b,
    input  wire        [rgbyc_pkg::COMP_W-1:0]   i_c,
    input  rgbyc_pkg::t_side                     i_side,
    output logic signed [rgbyc_pkg::NUM_W-1:0]   o_n0,
    output logic signed [rgbyc_pkg::NUM_W-1:0]   o_n1,
    output logic signed [rgbyc_pkg::NUM_W-1:0]   o_n2,
    output logic signed [rgbyc_pkg::NUM_W-1:0]   o_nl,
    output rgbyc_pkg::t_side                     o_side
);
    import rgbyc_pkg::*;

    logic signed [NUM_W-1:0] a, b, c, d, e, yl;
    logic signed [NUM_W-1:0] n_n0, n_n1, n_n2, n_nl;
    logic signed [NUM_W-1:0] r_n0, r_n1, r_n2, r_nl;
    t_side                   r_side;

    // Widen components and remove offsets
    always_comb begin
        a  = {{(NUM_W-COMP_W){1'b0}}, i_a};
        b  = {{(NUM_W-COMP_W){1'b0}}, i_b};
        c  = {{(NUM_W-COMP_W){1'b0}}, i_c};
        d  = b - CHROMA_OFS_N;
        e  = c - CHROMA_OFS_N;
        yl = a - LUMA_OFS_N;
    end

    // Form the matrix numerators in thousandths
    always_comb begin
        unique case (i_side.mode)
            MODE_RGB2YCC: begin
                n_n0 = K_Y_R * a + K_Y_G * b + K_Y_B * c;
                n_n1 = K_CB_B * c - K_CB_R * a - K_CB_G * b;
                n_n2 = K_CR_R * a - K_CR_G * b - K_CR_B * c;
                n_nl = '0;
            end
            MODE_YCC2RGB: begin
                n_n0 = K_R_CR * e;
                n_n1 = -(K_G_CB * d) - K_G_CR * e;
                n_n2 = K_B_CB * d;
                n_nl = K_LUMA * yl;
            end
            default: begin
                n_n0 = '0;
                n_n1 = '0;
                n_n2 = '0;
                n_nl = '0;
            end
        endcase
    end

    // Capture numerators
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_n0   <= n_n0;
            r_n1   <= n_n1;
            r_n2   <= n_n2;
            r_nl   <= n_nl;
            r_side <= i_side;
        end
    end

    assign o_n0   = r_n0;
    assign o_n1   = r_n1;
    assign o_n2   = r_n2;
    assign o_nl   = r_nl;
    assign o_side = r_side;

endmodule

`default_nettype wire

[sv/rgbyc_div1000.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbyc_div1000 (
    input  wire                                  i_clk,
    input  rgbyc_pkg::t_div_ctl                  i_ctl,
    input  wire                                  i_round,
    input  wire signed [rgbyc_pkg::NUM_W-1:0]    i_num,
    output logic       [rgbyc_pkg::Q_W-1:0]      o_q,
    output logic                                 o_neg
);
    import rgbyc_pkg::*;

    logic                    n_neg;
    logic signed [NUM_W-1:0] abs_v;
    logic [MAG_W-1:0]        n_mag;
    logic [PROD_W-1:0]       prod;
    logic                    r_neg_a, r_neg_b;
    logic [MAG_W-1:0]        r_mag;
    logic [Q_W-1:0]          r_q;

    // Split into sign and magnitude, add the rounding bias
    always_comb begin
        n_neg = i_num[NUM_W-1];
        abs_v = n_neg ? -i_num : i_num;
        n_mag = abs_v[MAG_W-1:0] + (i_round ? RND_BIAS : '0);
    end

    assign prod = PROD_W'(r_mag) * PROD_W'(DIV_REC);

    // Stage a holds the magnitude, stage b the quotient
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mag) begin
            r_neg_a <= n_neg;
            r_mag   <= n_mag;
        end
        if (i_ctl.ld_mul) begin
            r_neg_b <= r_neg_a;
            r_q     <= prod[PROD_W-1:SHIFT];
        end
    end

    assign o_q   = r_q;
    assign o_neg = r_neg_b;

endmodule

`default_nettype wire

[sv/rgbyc_finish.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbyc_finish (
    input  wire                               i_clk,
    input  wire                               i_ld,
    input  rgbyc_pkg::t_side                  i_side,
    input  wire  [rgbyc_pkg::Q_W-1:0]         i_q0,
    input  wire  [rgbyc_pkg::Q_W-1:0]         i_q1,
    input  wire  [rgbyc_pkg::Q_W-1:0]         i_q2,
    input  wire  [rgbyc_pkg::Q_W-1:0]         i_ql,
    input  wire  [3:0]                        i_neg,
    output logic [rgbyc_pkg::COMP_W-1:0]      o_res0,
    output logic [rgbyc_pkg::COMP_W-1:0]      o_res1,
    output logic [rgbyc_pkg::COMP_W-1:0]      o_res2,
    output rgbyc_pkg::t_side                  o_side
);
    import rgbyc_pkg::*;

    function automatic logic signed [SQ_W-1:0] apply_sign(input logic [Q_W-1:0] q,
                                                          input logic neg);
        logic signed [SQ_W-1:0] v;
        v = {1'b0, q};
        return neg ? -v : v;
    endfunction

    function automatic logic [COMP_W-1:0] sat8(input logic signed [SQ_W-1:0] luma,
                                               input logic signed [SQ_W-1:0] term);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(luma) + SUM_W'(term);
        if (s < 0) begin
            return '0;
        end else if (s > PIX_MAX) begin
            return PIX_SAT;
        end
        return s[COMP_W-1:0];
    endfunction

    logic signed [SQ_W-1:0] sq0, sq1, sq2, sql, fw0, fw1, fw2;
    logic [COMP_W-1:0]      n_res0, n_res1, n_res2;
    logic [COMP_W-1:0]      r_res0, r_res1, r_res2;
    t_side                  r_side;

    // Add offsets (forward) or luma with saturation (inverse)
    always_comb begin
        sq0 = apply_sign(i_q0, i_neg[0]);
        sq1 = apply_sign(i_q1, i_neg[1]);
        sq2 = apply_sign(i_q2, i_neg[2]);
        sql = apply_sign(i_ql, i_neg[3]);
        fw0 = sq0 + LUMA_OFS;
        fw1 = sq1 + CHROMA_OFS;
        fw2 = sq2 + CHROMA_OFS;
        unique case (i_side.mode)
            MODE_RGB2YCC: begin
                n_res0 = fw0[COMP_W-1:0];
                n_res1 = fw1[COMP_W-1:0];
                n_res2 = fw2[COMP_W-1:0];
            end
            MODE_YCC2RGB: begin
                n_res0 = sat8(sql, sq0);
                n_res1 = sat8(sql, sq1);
                n_res2 = sat8(sql, sq2);
            end
            default: begin
                n_res0 = '0;
                n_res1 = '0;
                n_res2 = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
            r_res2 <= n_res2;
            r_side <= i_side;
        end
    end

    assign o_res0 = r_res0;
    assign o_res1 = r_res1;
    assign o_res2 = r_res2;
    assign o_side = r_side;

endmodule

`default_nettype wire

[sv/rgb_ycbcr_integer_converter.sv]
// Four-stage pipeline: matrix, magnitude, reciprocal multiply, offset/saturate;
// each accepted request passes them in that order to its result on o_pix.
// Throughput: one pixel per cycle while o_pix is ready; the pipeline accepts a
// request every cycle unless a stalled output has backed up stage by stage to the
// first stage; empty stages still take requests. Reset (synchronous, active low)
// clears all valid bits and sets the mode to RGB to YCbCr.
`timescale 1ns / 1ps
`default_nettype none

module rgb_ycbcr_integer_converter (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_wdata,
    rgbyc_in_if.sink           i_pix,
    rgbyc_out_if.source        o_pix
);
    import rgbyc_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic ld1, ld2, ld3, ld4;
    t_mode r_mode;
    t_side in_side, side1, side4, r_side2, r_side3;
    t_div_ctl div_ctl;

    logic signed [NUM_W-1:0] n0, n1, n2, nl;
    logic [Q_W-1:0]          q0, q1, q2, ql;
    logic [3:0]              neg;
    logic [COMP_W-1:0]       res0, res1, res2;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RGB2YCC;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    // Stage loads: a stage advances when empty or when its request moves on
    assign ld4 = !r_v4 || o_pix.ready;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    assign i_pix.ready = ld1;
    assign div_ctl     = '{ld_mag: ld2, ld_mul: ld3};

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_pix.valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
        end
    end

    // Carry side information through the divider stages
    always_ff @(posedge i_clk) begin
        if (ld2) r_side2 <= side1;
        if (ld3) r_side3 <= r_side2;
    end

    assign in_side = '{mode: r_mode, last: i_pix.last_in};

    rgbyc_matrix u_matrix (
        .i_clk  (i_clk),
        .i_ld   (ld1),
        .i_a    (i_pix.comp_first),
        .i_b    (i_pix.comp_second),
        .i_c    (i_pix.comp_third),
        .i_side (in_side),
        .o_n0   (n0),
        .o_n1   (n1),
        .o_n2   (n2),
        .o_nl   (nl),
        .o_side (side1)
    );

    rgbyc_div1000 u_div0 (
        .i_clk (i_clk), .i_ctl (div_ctl), .i_round (1'b1),
        .i_num (n0), .o_q (q0), .o_neg (neg[0])
    );
    rgbyc_div1000 u_div1 (
        .i_clk (i_clk), .i_ctl (div_ctl), .i_round (1'b1),
        .i_num (n1), .o_q (q1), .o_neg (neg[1])
    );
    rgbyc_div1000 u_div2 (
        .i_clk (i_clk), .i_ctl (div_ctl), .i_round (1'b1),
        .i_num (n2), .o_q (q2), .o_neg (neg[2])
    );
    // Luma term truncates toward zero: no rounding bias
    rgbyc_div1000 u_divl (
        .i_clk (i_clk), .i_ctl (div_ctl), .i_round (1'b0),
        .i_num (nl), .o_q (ql), .o_neg (neg[3])
    );

    rgbyc_finish u_finish (
        .i_clk  (i_clk),
        .i_ld   (ld4),
        .i_side (r_side3),
        .i_q0   (q0),
        .i_q1   (q1),
        .i_q2   (q2),
        .i_ql   (ql),
        .i_neg  (neg),
        .o_res0 (res0),
        .o_res1 (res1),
        .o_res2 (res2),
        .o_side (side4)
    );

    assign o_pix.valid      = r_v4;
    assign o_pix.res_first  = res0;
    assign o_pix.res_second = res1;
    assign o_pix.res_third  = res2;
    assign o_pix.last_out   = side4.last;

    // An accepted request occupies the first stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_v1)
        else $error("accepted request missing from first stage");

    // A blocked third stage keeps its request
    a_stage3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !ld4) |=> r_v3)
        else $error("third stage dropped a stalled request");

    // Forward results stay within studio range
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && side4.mode == MODE_RGB2YCC) |->
        (res0 >= 8'd16 && res0 <= 8'd240 && res1 >= 8'd16 && res1 <= 8'd240 &&
         res2 >= 8'd16 && res2 <= 8'd240))
        else $error("forward result outside studio range");

endmodule

`default_nettype wire

[bench/rgb_ycbcr_integer_converter_test.sv]
`timescale 1ns / 1ps

module rgb_ycbcr_integer_converter_test;
    import rgbyc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 12;     // pipeline depth plus margin
    localparam int HOLD_LEN     = 160;    // long receiver hold-off
    localparam int RAND_PER_SET = 150;
    localparam int SHOW_MAX     = 10;

    typedef struct {
        logic [COMP_W-1:0] first;
        logic [COMP_W-1:0] second;
        logic [COMP_W-1:0] third;
        logic              last;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    rgbyc_in_if  pix_in ();
    rgbyc_out_if pix_out ();

    rgb_ycbcr_integer_converter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    t_pixel pending_pixels[$];
    t_pixel converted_expect[$];
    t_mode  mode_shadow;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_req_cnt;
    int     hold_ack_cnt;
    int     hold_left;
    int     mismatch_cnt;
    int     cycle_cnt;

    // Round num/1000 half away from zero
    function automatic int milli_round(int num);
        if (num < 0) begin
            return -((-num + 500) / 1000);
        end
        return (num + 500) / 1000;
    endfunction

    function automatic logic [COMP_W-1:0] clip_pixel(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 255) begin
            return '1;
        end
        return COMP_W'(v);
    endfunction

    // Expected converted pixel for one request
    function automatic t_pixel convert_pixel(t_pixel px, t_mode mode);
        int     a;
        int     b;
        int     c;
        int     luma;
        int     d;
        int     e;
        t_pixel r;
        a = px.first;
        b = px.second;
        c = px.third;
        if (mode == MODE_RGB2YCC) begin
            r.first  = COMP_W'(milli_round(257 * a + 504 * b + 98 * c) + 16);
            r.second = COMP_W'(milli_round(-148 * a - 291 * b + 439 * c) + 128);
            r.third  = COMP_W'(milli_round(439 * a - 368 * b - 71 * c) + 128);
        end else begin
            // luma term truncates toward zero, also below black level
            luma     = (1164 * (a - 16)) / 1000;
            d        = b - 128;
            e        = c - 128;
            r.first  = clip_pixel(luma + milli_round(1596 * e));
            r.second = clip_pixel(luma + milli_round(-392 * d - 813 * e));
            r.third  = clip_pixel(luma + milli_round(2017 * d));
        end
        r.last = px.last;
        return r;
    endfunction

    function automatic logic [COMP_W-1:0] pick_comp(int edge_pct);
        logic [COMP_W-1:0] corner[6] = '{8'd0, 8'd255, 8'd16, 8'd15, 8'd128, 8'd240};
        if ($urandom_range(99) < edge_pct) begin
            return corner[$urandom_range(5)];
        end
        return COMP_W'($urandom_range(255));
    endfunction

    task automatic push_pixel(int a, int b, int c, bit last);
        t_pixel px;
        px.first  = COMP_W'(a);
        px.second = COMP_W'(b);
        px.third  = COMP_W'(c);
        px.last   = last;
        pending_pixels.push_back(px);
    endtask

    task automatic push_random(int n);
        t_pixel px;
        repeat (n) begin
            px.first  = pick_comp(15);
            px.second = pick_comp(15);
            px.third  = pick_comp(15);
            px.last   = ($urandom_range(7) == 0);
            pending_pixels.push_back(px);
        end
    endtask

    // Wait until every request is sent and every result checked
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_pixels.size() != 0 || pix_in.valid || converted_expect.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    // Write the direction register while the block is idle
    task automatic write_mode(t_mode m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        mode_shadow <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge i_clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        @(negedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // Sender: offer pending requests, idle at random
    always @(posedge i_clk) begin
        t_pixel px;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else if (!pix_in.valid || pix_in.ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                px = pending_pixels.pop_front();
                pix_in.comp_first  <= px.first;
                pix_in.comp_second <= px.second;
                pix_in.comp_third  <= px.third;
                pix_in.last_in     <= px.last;
                pix_in.valid       <= 1'b1;
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt  <= hold_req_cnt;
            hold_left     <= HOLD_LEN;
            pix_out.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predict each accepted request
    always @(posedge i_clk) begin
        t_pixel px;
        if (i_rst_n && pix_in.valid && pix_in.ready) begin
            px.first  = pix_in.comp_first;
            px.second = pix_in.comp_second;
            px.third  = pix_in.comp_third;
            px.last   = pix_in.last_in;
            converted_expect.push_back(convert_pixel(px, mode_shadow));
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (converted_expect.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < SHOW_MAX) begin
                    $display("unexpected result %0d %0d %0d last=%0b",
                             pix_out.res_first, pix_out.res_second,
                             pix_out.res_third, pix_out.last_out);
                end
            end else begin
                want = converted_expect.pop_front();
                if (pix_out.res_first !== want.first || pix_out.res_second !== want.second
                    || pix_out.res_third !== want.third || pix_out.last_out !== want.last) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < SHOW_MAX) begin
                        $display("mismatch: expected %0d %0d %0d last=%0b, got %0d %0d %0d last=%0b",
                                 want.first, want.second, want.third, want.last,
                                 pix_out.res_first, pix_out.res_second,
                                 pix_out.res_third, pix_out.last_out);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** rgb_ycbcr_integer_converter: FAILED **");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int send_pct[4] = '{0, 62, 0, 37};
        int recv_pct[4] = '{0, 0, 62, 37};
        pix_in.valid       = 1'b0;
        pix_in.comp_first  = '0;
        pix_in.comp_second = '0;
        pix_in.comp_third  = '0;
        pix_in.last_in     = 1'b0;
        pix_out.ready      = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 1'b0;
        i_rst_n            = 1'b0;
        mode_shadow        = MODE_RGB2YCC;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_req_cnt       = 0;
        hold_ack_cnt       = 0;
        hold_left          = 0;
        mismatch_cnt       = 0;
        cycle_cnt          = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Forward corners: primaries, secondaries, black, white, gray, one mixed color
        write_mode(MODE_RGB2YCC);
        push_pixel(0, 0, 0, 0);
        push_pixel(255, 255, 255, 1);
        push_pixel(255, 0, 0, 0);
        push_pixel(0, 255, 0, 1);
        push_pixel(0, 0, 255, 0);
        push_pixel(0, 255, 255, 0);
        push_pixel(255, 0, 255, 1);
        push_pixel(255, 255, 0, 0);
        push_pixel(128, 128, 128, 1);
        push_pixel(85, 170, 51, 0);
        wait_drained();

        // Inverse corners: luma below black level, saturation both ways
        write_mode(MODE_YCC2RGB);
        push_pixel(0, 128, 128, 0);
        push_pixel(15, 128, 128, 1);
        push_pixel(16, 128, 128, 0);
        push_pixel(235, 128, 128, 0);
        push_pixel(255, 255, 255, 1);
        push_pixel(255, 0, 0, 0);
        push_pixel(0, 0, 0, 1);
        push_pixel(0, 255, 255, 0);
        push_pixel(128, 0, 255, 0);
        push_pixel(128, 255, 0, 1);
        push_pixel(235, 240, 16, 0);
        push_pixel(16, 16, 240, 1);
        wait_drained();

        // Random sets: every idling pattern in both directions
        for (int k = 0; k < 8; k++) begin
            write_mode((k % 2 == 0) ? MODE_RGB2YCC : MODE_YCC2RGB);
            set_idling(send_pct[(k / 2) % 4], recv_pct[(k / 2) % 4]);
            push_random(RAND_PER_SET);
            wait_drained();
        end

        // Back-pressure: receiver holds off while the sender keeps offering
        write_mode(MODE_YCC2RGB);
        set_idling(0, 10);
        push_random(60);
        hold_req_cnt <= hold_req_cnt + 1;
        wait_drained();

        if (mismatch_cnt == 0) begin
            $display("** rgb_ycbcr_integer_converter: PASSED **");
        end else begin
            $display("** rgb_ycbcr_integer_converter: FAILED **");
        end
        $finish;
    end

endmodule
